// ===== sv/ekc_pkg.sv =====
package ekc_pkg;

  // Default sizes
  localparam int unsigned EKC_FIFO_DEPTH = 256;
  localparam int unsigned EKC_NUM_KEYS   = 256;
  localparam int unsigned EKC_TIME_WIDTH = 32;

  // Fixed field widths
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned KEY_W    = 8;
  localparam int unsigned NOW_W    = 32;
  localparam int unsigned WINDOW_W = 32;
  localparam int unsigned COUNT_W  = 9;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 32'd300;
  localparam logic [COUNT_W-1:0]  COUNT_SAT    = 9'd511;

  // Request commands
  localparam logic [CMD_W-1:0] CMD_PUT       = 2'd0;
  localparam logic [CMD_W-1:0] CMD_GET_COUNT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_GET_TOTAL = 2'd2;

  // Response status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_DROPPED = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture the accepted request
    logic clear_wr;  // write one zero entry of the count table
    logic pop_rd;    // read the count of the head event's key
    logic pop;       // retire the head event
    logic finish;    // execute the command and load the response
  } ekc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;
    logic fifo_empty;
    logic expired;
    logic out_free;
  } ekc_sts_t;

endpackage

// ===== sv/ekc_ifs.sv =====
interface ekc_req_if;
  logic                        valid;
  logic                        ready;
  logic [ekc_pkg::CMD_W-1:0]   command;
  logic [ekc_pkg::KEY_W-1:0]   key;
  logic [ekc_pkg::NOW_W-1:0]   now;

  modport source (output valid, command, key, now, input ready);
  modport sink   (input valid, command, key, now, output ready);
endinterface

interface ekc_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [ekc_pkg::COUNT_W-1:0] count;
  logic                        status;

  modport source (output valid, count, status, input ready);
  modport sink   (input valid, count, status, output ready);
endinterface

interface ekc_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [ekc_pkg::WINDOW_W-1:0] window;

  modport source (output valid, window, input ready);
  modport sink   (input valid, window, output ready);
endinterface

// ===== sv/ekc_ram.sv =====
module ekc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, registered read (old data on a same-address collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/ekc_ctrl.sv =====
module ekc_ctrl import ekc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  ekc_sts_t sts,
  output ekc_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_POP,
    S_FINISH
  } state_t;

  state_t state, state_next;

  // Sequence: clear once, then per request check/pop expired events, then finish
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid && req_ready) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts.fifo_empty && sts.expired) begin
          cmd.pop_rd = 1'b1;
          state_next = S_POP;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_POP: begin
        cmd.pop    = 1'b1;
        state_next = S_CHECK;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold state and the registered ready
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      req_ready <= 1'b0;
    end else begin
      state     <= state_next;
      req_ready <= (state_next == S_IDLE);
    end
  end

endmodule

// ===== sv/ekc_datapath.sv =====
module ekc_datapath import ekc_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = EKC_FIFO_DEPTH,
  parameter int unsigned NUM_KEYS   = EKC_NUM_KEYS,
  parameter int unsigned TIME_WIDTH = EKC_TIME_WIDTH
) (
  input  logic                clk,
  input  logic                rst,
  input  ekc_cmd_t            cmd,
  output ekc_sts_t            sts,
  input  logic [CMD_W-1:0]    req_command,
  input  logic [KEY_W-1:0]    req_key,
  input  logic [NOW_W-1:0]    req_now,
  input  logic                cfg_we,
  input  logic [WINDOW_W-1:0] cfg_window,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output logic [COUNT_W-1:0]  rsp_count,
  output logic                rsp_status
);

  localparam int unsigned KIDX_W   = $clog2(NUM_KEYS);
  localparam int unsigned FIDX_W   = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W    = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned EV_W     = TIME_WIDTH + KIDX_W;
  localparam int unsigned AGE_W    = (TIME_WIDTH > WINDOW_W) ? TIME_WIDTH : WINDOW_W;
  localparam int unsigned SAT_W    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int unsigned KEY_VALS = 1 << KEY_W;

  logic [WINDOW_W-1:0]   window;
  logic [CMD_W-1:0]      cmd_r;
  logic [KIDX_W-1:0]     key_r;
  logic [TIME_WIDTH-1:0] now_r;
  logic [FIDX_W-1:0]     head, tail, head_inc, tail_inc;
  logic [CNT_W-1:0]      occ;
  logic [KIDX_W-1:0]     clr_addr;

  logic [KIDX_W-1:0]     key_tbl [KEY_VALS];
  logic [EV_W-1:0]       fifo_rdata;
  logic [TIME_WIDTH-1:0] ev_time, age;
  logic [KIDX_W-1:0]     ev_key;
  logic                  fifo_full, is_put, do_push;

  logic                  cnt_we;
  logic [KIDX_W-1:0]     cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0]      cnt_wdata, cnt_rdata, cnt_inc, cnt_dec;

  // Key reduction table, worked out at elaboration
  for (genvar gi = 0; gi < KEY_VALS; gi++) begin : g_key_tbl
    assign key_tbl[gi] = KIDX_W'(gi % NUM_KEYS);
  end

  function automatic logic [COUNT_W-1:0] sat_count(input logic [CNT_W-1:0] v);
    logic [SAT_W-1:0] ext;
    ext = SAT_W'(v);
    return (ext > SAT_W'(COUNT_SAT)) ? COUNT_SAT : COUNT_W'(ext);
  endfunction

  // Head event fields and its age
  assign ev_time  = fifo_rdata[EV_W-1:KIDX_W];
  assign ev_key   = fifo_rdata[KIDX_W-1:0];
  assign age      = now_r - ev_time;
  assign head_inc = (head == FIDX_W'(FIFO_DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_inc = (tail == FIDX_W'(FIFO_DEPTH - 1)) ? '0 : tail + 1'b1;

  assign fifo_full = (occ == CNT_W'(FIFO_DEPTH));
  assign is_put    = (cmd_r == CMD_PUT);
  assign do_push   = cmd.finish && is_put && !fifo_full;

  assign sts.clear_last = (clr_addr == KIDX_W'(NUM_KEYS - 1));
  assign sts.fifo_empty = (occ == '0);
  assign sts.expired    = (AGE_W'(age) > AGE_W'(window));
  assign sts.out_free   = !rsp_valid || rsp_ready;

  // Event FIFO storage: read address runs ahead of the head on a pop
  ekc_ram #(
    .WIDTH (EV_W),
    .DEPTH (FIFO_DEPTH)
  ) u_event_ram (
    .clk   (clk),
    .we    (do_push),
    .waddr (tail),
    .wdata ({now_r, key_r}),
    .raddr (cmd.pop ? head_inc : head),
    .rdata (fifo_rdata)
  );

  // Per-key counts
  assign cnt_inc   = cnt_rdata + CNT_W'(1);
  assign cnt_dec   = (cnt_rdata == '0) ? '0 : cnt_rdata - CNT_W'(1);
  assign cnt_raddr = cmd.pop_rd ? ev_key : key_r;

  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = key_r;
    cnt_wdata = cnt_inc;
    if (cmd.clear_wr) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_addr;
      cnt_wdata = '0;
    end else if (cmd.pop) begin
      cnt_we    = 1'b1;
      cnt_waddr = ev_key;
      cnt_wdata = cnt_dec;
    end else if (do_push) begin
      cnt_we    = 1'b1;
    end
  end

  ekc_ram #(
    .WIDTH (CNT_W),
    .DEPTH (NUM_KEYS)
  ) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  // Capture the request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= req_command;
      key_r <= key_tbl[req_key];
      now_r <= TIME_WIDTH'(req_now);
    end
  end

  // Window register, clear sweep address, FIFO pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      window   <= WINDOW_RESET;
      clr_addr <= '0;
      head     <= '0;
      tail     <= '0;
      occ      <= '0;
    end else begin
      if (cfg_we) begin
        window <= cfg_window;
      end
      if (cmd.clear_wr) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.pop) begin
        head <= head_inc;
        occ  <= occ - CNT_W'(1);
      end else if (do_push) begin
        tail <= tail_inc;
        occ  <= occ + CNT_W'(1);
      end
    end
  end

  // Response register: load on finish, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      case (cmd_r)
        CMD_PUT: begin
          if (fifo_full) begin
            rsp_count  <= sat_count(cnt_rdata);
            rsp_status <= STATUS_DROPPED;
          end else begin
            rsp_count  <= sat_count(cnt_inc);
            rsp_status <= STATUS_OK;
          end
        end
        CMD_GET_COUNT: begin
          rsp_count  <= sat_count(cnt_rdata);
          rsp_status <= STATUS_OK;
        end
        CMD_GET_TOTAL: begin
          rsp_count  <= sat_count(occ);
          rsp_status <= STATUS_OK;
        end
        default: begin
          rsp_count  <= '0;
          rsp_status <= STATUS_OK;
        end
      endcase
    end
  end

endmodule

// ===== sv/expiring_key_counter_core.sv =====
// Sliding-window event counter with per-key counts.
// req channel: command (put, get count, get total), key and the current time.
// rsp channel: one response per request, count and status (1 = put dropped,
// event FIFO full). cfg channel: writes the window register, always ready;
// write it only while no request is in flight.
// Sequence: a request is taken, then every expired event at the FIFO head
// costs a head check and a count read-modify-write through the key-count
// memory port, then a last head check and a step that executes the command.
// The response register is loaded at the end and is visible the next cycle.
// The response sits in an output register, so the next request is accepted
// while it waits; a stalled receiver holds the block in its final step until
// the register frees.
// Reset: window returns to 300, the FIFO empties, and the key-count memory
// is swept to zero, one entry per cycle over all NUM_KEYS entries, with req.ready low.
module expiring_key_counter_core import ekc_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = EKC_FIFO_DEPTH,
  parameter int unsigned NUM_KEYS   = EKC_NUM_KEYS,
  parameter int unsigned TIME_WIDTH = EKC_TIME_WIDTH
) (
  input logic        clk,
  input logic        rst,
  ekc_req_if.sink    req,
  ekc_rsp_if.source  rsp,
  ekc_cfg_if.sink    cfg
);

  ekc_cmd_t cmd;
  ekc_sts_t sts;

  assign cfg.ready = 1'b1;

  ekc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ekc_datapath #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .NUM_KEYS   (NUM_KEYS),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .req_command (req.command),
    .req_key     (req.key),
    .req_now     (req.now),
    .cfg_we      (cfg.valid && cfg.ready),
    .cfg_window  (cfg.window),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_count   (rsp.count),
    .rsp_status  (rsp.status)
  );

endmodule
